>>> hdl/hamming_single_error_codec_defines.svh
// assertion macros used by the codec checker
`ifndef HAMMING_SINGLE_ERROR_CODEC_DEFINES_SVH
`define HAMMING_SINGLE_ERROR_CODEC_DEFINES_SVH

// same-cycle implication, held off during reset
`define HSEC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hsec assertion failed");

// next-cycle implication, held off during reset
`define HSEC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hsec assertion failed");

`endif

>>> hdl/hsec_pkg.sv
// constants and code position functions for the hamming codec
`default_nettype none

package hsec_pkg;

    localparam int CODE_BITS             = 64;
    localparam int DATA_BITS             = 57;
    localparam int SYN_BITS              = 6;
    localparam int CFG_BITS              = 6;
    localparam int MAX_CODE_BITS_DEFAULT = 64;
    localparam int ADDR_BITS             = 3;
    localparam int APB_DATA_BITS         = 32;
    localparam int RESULT_BITS           = CODE_BITS + DATA_BITS + SYN_BITS + 1;

    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(4);

    // register index, taken from paddr[ADDR_BITS-1]
    localparam logic REG_DATA_BIT_COUNT = 1'b0;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    function automatic logic is_pow2(input int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    // least r with 2^r >= m + r + 1
    function automatic logic [2:0] parity_count(input logic [CFG_BITS-1:0] m);
        logic [2:0] r;
        r = 3'd7;
        for (int k = 6; k >= 0; k--) begin
            if ((1 << k) >= (int'(m) + k + 1)) begin
                r = 3'(k);
            end
        end
        return r;
    endfunction

    function automatic int largest_m(input int max_code);
        int best;
        best = 1;
        for (int m = 1; m <= DATA_BITS; m++) begin
            if (m + int'(parity_count(CFG_BITS'(m))) <= max_code) begin
                best = m;
            end
        end
        return best;
    endfunction

    function automatic logic [SYN_BITS-1:0] syndrome(input logic [CODE_BITS-1:0] code);
        logic [SYN_BITS-1:0] s;
        s = '0;
        for (int p = 1; p < CODE_BITS; p++) begin
            for (int i = 0; i < SYN_BITS; i++) begin
                if (p[i]) begin
                    s[i] = s[i] ^ code[p-1];
                end
            end
        end
        return s;
    endfunction

    // data bits into the non power of two positions
    function automatic logic [CODE_BITS-1:0] scatter(input logic [DATA_BITS-1:0] d);
        logic [CODE_BITS-1:0] c;
        int j;
        c = '0;
        j = 0;
        for (int p = 1; p < CODE_BITS; p++) begin
            if (!is_pow2(p)) begin
                c[p-1] = d[j];
                j++;
            end
        end
        return c;
    endfunction

    function automatic logic [DATA_BITS-1:0] gather(input logic [CODE_BITS-1:0] c);
        logic [DATA_BITS-1:0] d;
        int j;
        d = '0;
        j = 0;
        for (int p = 1; p < CODE_BITS; p++) begin
            if (!is_pow2(p)) begin
                d[j] = c[p-1];
                j++;
            end
        end
        return d;
    endfunction

endpackage

`default_nettype wire

>>> hdl/hamming_single_error_codec.sv
// hamming single error correcting codec with configurable data length
//
// channel   dir  ports                         transaction
// s_        in   s_tvalid/s_tready/s_tdata/..  func and word to encode or check
// m_        out  m_tvalid/m_tready/m_tdata     codeword, data, syndrome, range flag
// apb       in   psel/penable/pwrite/paddr/..  data_bit_count at byte address 0
//
// one transaction per cycle sustained while m_tready is high; a word passes the
// input register, xor trees and correction, then the result register
// aresetn is synchronous; it empties both stages and sets data_bit_count to 4
// a stalled result holds; the input stage still fills behind it
`default_nettype none

module hamming_single_error_codec
    import hsec_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_BITS-1:0]     paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [CODE_BITS-1:0]     s_tdata,     // word_in
    input  wire logic [0:0]               s_tuser,     // func
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // code_out, data_out, error_position, out_of_range
    output logic      [RESULT_BITS-1:0]   m_tdata
);

    localparam logic [CFG_BITS-1:0] TOP_M = CFG_BITS'(largest_m(MAX_CODE_BITS));

    logic [CFG_BITS-1:0]    data_bit_count_reg;
    logic                   in_valid_reg;
    logic                   in_func_reg;
    logic [CODE_BITS-1:0]   in_word_reg;
    logic                   out_valid_reg;
    logic [RESULT_BITS-1:0] m_tdata_reg;
    logic [RESULT_BITS-1:0] m_tdata_next;
    logic                   cfg_write;
    logic                   adv_out;

    logic [CFG_BITS-1:0]    m_eff;
    logic [2:0]             r_cnt;
    logic [CFG_BITS-1:0]    n_len;
    logic [CODE_BITS-1:0]   mask_m;
    logic [CODE_BITS-1:0]   mask_n;
    logic [CODE_BITS-1:0]   enc_data;
    logic [CODE_BITS-1:0]   enc_base;
    logic [SYN_BITS-1:0]    enc_par;
    logic [CODE_BITS-1:0]   enc_code;
    logic [CODE_BITS-1:0]   dec_rx;
    logic [SYN_BITS-1:0]    dec_syn;
    logic                   dec_oor;
    logic [CODE_BITS-1:0]   dec_flip;
    logic [CODE_BITS-1:0]   dec_code;

    // configuration port
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[ADDR_BITS-1] == REG_DATA_BIT_COUNT)
                     ? APB_DATA_BITS'(data_bit_count_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_bit_count_reg <= CFG_RESET;
        end else if (cfg_write && paddr[ADDR_BITS-1] == REG_DATA_BIT_COUNT) begin
            data_bit_count_reg <= pwdata[CFG_BITS-1:0];
        end
    end

    // two stage flow control
    assign adv_out  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || adv_out;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (adv_out) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg <= s_tuser[0];
            in_word_reg <= s_tdata;
        end
        if (adv_out && in_valid_reg) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // code geometry from the register
    always_comb begin
        if (data_bit_count_reg == '0) begin
            m_eff = CFG_BITS'(1);
        end else if (data_bit_count_reg > TOP_M) begin
            m_eff = TOP_M;
        end else begin
            m_eff = data_bit_count_reg;
        end
        r_cnt  = parity_count(m_eff);
        n_len  = m_eff + CFG_BITS'(r_cnt);
        mask_m = ~({CODE_BITS{1'b1}} << m_eff);
        mask_n = ~({CODE_BITS{1'b1}} << n_len);
    end

    // encode: parity positions start at zero, so the syndrome gives them
    always_comb begin
        enc_data = in_word_reg & mask_m;
        enc_base = scatter(enc_data[DATA_BITS-1:0]);
        enc_par  = syndrome(enc_base);
        enc_code = enc_base;
        for (int i = 0; i < SYN_BITS; i++) begin
            enc_code[(1 << i) - 1] = enc_par[i];
        end
    end

    // decode: correct the named bit unless it lies beyond the code
    always_comb begin
        dec_rx   = in_word_reg & mask_n;
        dec_syn  = syndrome(dec_rx);
        dec_oor  = dec_syn > n_len;
        dec_flip = '0;
        if (!dec_oor && dec_syn != '0) begin
            dec_flip = CODE_BITS'(1) << (dec_syn - SYN_BITS'(1));
        end
        dec_code = dec_rx ^ dec_flip;
    end

    always_comb begin
        case (in_func_reg)
            FUNC_ENCODE: begin
                m_tdata_next = {1'b0, {SYN_BITS{1'b0}}, enc_data[DATA_BITS-1:0], enc_code};
            end
            FUNC_DECODE: begin
                m_tdata_next = {dec_oor, dec_syn, gather(dec_code), dec_code};
            end
            default: begin
                m_tdata_next = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/hsec_checker.sv
// port level checks for the hamming codec, bound to the top level
`default_nettype none

`include "hamming_single_error_codec_defines.svh"

module hsec_checker
    import hsec_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [RESULT_BITS-1:0] m_tdata
);

    localparam int OOR_BIT = RESULT_BITS - 1;
    localparam int SYN_LO  = CODE_BITS + DATA_BITS;

    logic                 res_stall;
    logic                 res_oor;
    logic [SYN_BITS-1:0]  res_syn;
    logic [CODE_BITS-1:0] res_code;

    assign res_stall = m_tvalid && !m_tready;
    assign res_oor   = m_tdata[OOR_BIT];
    assign res_syn   = m_tdata[OOR_BIT-1:SYN_LO];
    assign res_code  = m_tdata[CODE_BITS-1:0];

    // a stalled result transaction holds its payload
    `HSEC_ASSERT_NEXT(a_stall_hold, aclk, aresetn, res_stall, m_tvalid && $stable(m_tdata))

    // a taken result always frees the input side
    `HSEC_ASSERT_SAME(a_ready_follows, aclk, aresetn, m_tready, s_tready)

    // an out of range flag comes only with a nonzero syndrome
    `HSEC_ASSERT_SAME(a_oor_syn, aclk, aresetn, m_tvalid && res_oor, res_syn != '0)

    // every encoded or corrected codeword checks clean
    `HSEC_ASSERT_SAME(a_code_clean, aclk, aresetn, m_tvalid && !res_oor, syndrome(res_code) == '0)

endmodule

bind hamming_single_error_codec hsec_checker u_hsec_checker (.*);

`default_nettype wire
